/* rtl/mcst_pkg.sv */
// Shared types and codes for the multi-slot countdown timer.
// No dependencies; the slot unit, top level, checker and testbench import this package.
package mcst_pkg;

    // Command codes carried in the op field of an input beat.
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_CANCEL  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Reply status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_CANCELED = 3'd4;

    // Result kinds.
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Slot phases.
    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_DONE   = 2'd1;
    localparam logic [1:0] PH_CANCEL = 2'd2;

    // At most this many expiry events come out of one tick.
    localparam int MAX_EVENTS = 16;
    localparam int EV_W       = $clog2(MAX_EVENTS + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] delay;
        logic [5:0]  slot_id;
    } in_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [5:0] slot_out;
        logic       last;
    } out_t;

    // One entry of the slot table memory.
    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] count;
    } entry_t;

    // Decision of the slot update unit for the entry under evaluation.
    typedef struct packed {
        logic       wr_en;
        entry_t     entry;
        logic [2:0] status;
        logic       fire;
    } slot_upd_t;

endpackage

/* rtl/mcst_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mcst_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port whose data holds until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/mcst_slot_unit.sv */
// Shared slot update unit: decrement, zero compare and phase decision for
// one table entry, used by both the tick walk and the cancel command.
// Depends on mcst_pkg.
module mcst_slot_unit (
    input  logic               is_tick,
    input  logic               can_fire,
    input  mcst_pkg::entry_t   entry,
    output mcst_pkg::slot_upd_t upd
);
    import mcst_pkg::*;

    // Decide the write-back, the reply status and whether the slot expires.
    always_comb begin
        upd        = '0;
        upd.entry  = entry;
        upd.status = ST_OK;
        if (is_tick) begin
            if (entry.phase == PH_WAIT) begin
                if (entry.count != 16'd0) begin
                    upd.wr_en       = 1'b1;
                    upd.entry.count = entry.count - 16'd1;
                end else if (can_fire) begin
                    upd.wr_en       = 1'b1;
                    upd.entry.phase = PH_DONE;
                    upd.fire        = 1'b1;
                end
            end
        end else begin
            if (entry.phase == PH_WAIT) begin
                upd.wr_en       = 1'b1;
                upd.entry.phase = PH_CANCEL;
            end else if (entry.phase == PH_CANCEL) begin
                upd.status = ST_CANCELED;
            end else begin
                upd.status = ST_BUSY;
            end
        end
    end

endmodule

/* rtl/multi_slot_countdown_timer_top.sv */
// Top level of the multi-slot countdown timer: sequencer, slot flags and
// output register. Depends on mcst_pkg, mcst_ram and mcst_slot_unit.
//
// One beat is taken at a time; s_ready is low while a command or tick is
// being worked. The slot table lives in a RAM with one read and one write
// port, and the sequencer walks it one slot at a time. Cancel passes
// S_CHECK, S_CMD_EVAL and S_REPLY; an invalid id or a free slot skips
// S_CMD_EVAL. Release passes S_CHECK and S_REPLY. Add stays in S_ADD
// for each slot up to the lowest free one. A tick visits S_TICK_SCAN per
// slot, S_TICK_EVAL per used slot, then S_FLUSH. A result register held
// by m_ready low stalls S_REPLY, S_FLUSH and an expiry push in
// S_TICK_EVAL. A tick that expires nothing gives no result beat; the
// expiry beats of one tick come out in slot order, the final one with last.
module multi_slot_countdown_timer_top #(
    parameter int SLOT_COUNT = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mcst_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mcst_pkg::out_t  m_data
);
    import mcst_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [6:0] SLOT_LIMIT = 7'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMD_EVAL,
        S_ADD,
        S_TICK_SCAN,
        S_TICK_EVAL,
        S_FLUSH,
        S_REPLY
    } state_t;

    state_t               state_reg, state_next;
    in_t                  cmd_reg, cmd_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [2:0]           rsp_status_reg, rsp_status_next;
    logic [5:0]           rsp_slot_reg, rsp_slot_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [EV_W-1:0]      ev_cnt_reg, ev_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    logic                 ram_wr_en;
    entry_t               ram_wr_data;
    logic                 ram_rd_en;
    logic [$bits(entry_t)-1:0] ram_rd_raw;
    entry_t               ram_rd_data;
    slot_upd_t            upd;
    logic                 out_free;
    logic                 id_ok;
    logic                 idx_last;
    logic                 cur_used;

    // Slot table: phase and remaining count per slot.
    mcst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_raw)
    );

    assign ram_rd_data = entry_t'(ram_rd_raw);

    // Shared update unit for tick and cancel evaluation.
    mcst_slot_unit u_unit (
        .is_tick  (cmd_reg.op == OP_TICK),
        .can_fire (ev_cnt_reg < EV_W'(MAX_EVENTS)),
        .entry    (ram_rd_data),
        .upd      (upd)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign id_ok    = {1'b0, cmd_reg.slot_id} < SLOT_LIMIT;
    assign idx_last = (idx_reg == LAST_IDX);
    assign cur_used = used_reg[idx_reg];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer next-state and datapath control.
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        ev_cnt_next     = ev_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_wr_en       = 1'b0;
        ram_wr_data     = upd.entry;
        ram_rd_en       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_data;
                    ev_cnt_next = '0;
                    case (s_data.op)
                        OP_ADD: begin
                            idx_next   = '0;
                            state_next = S_ADD;
                        end
                        OP_TICK: begin
                            idx_next   = '0;
                            state_next = S_TICK_SCAN;
                        end
                        default: begin
                            idx_next   = s_data.slot_id[IDX_W-1:0];
                            state_next = S_CHECK;
                        end
                    endcase
                end
            end

            // Cancel and release: range and occupancy check.
            S_CHECK: begin
                rsp_slot_next = cmd_reg.slot_id;
                if (!id_ok) begin
                    rsp_status_next = ST_INVALID;
                    state_next      = S_REPLY;
                end else if (cmd_reg.op == OP_RELEASE) begin
                    used_next[idx_reg] = 1'b0;
                    rsp_status_next    = ST_OK;
                    state_next         = S_REPLY;
                end else if (!cur_used) begin
                    rsp_status_next = ST_INVALID;
                    state_next      = S_REPLY;
                end else begin
                    ram_rd_en  = 1'b1;
                    state_next = S_CMD_EVAL;
                end
            end

            S_CMD_EVAL: begin
                ram_wr_en       = upd.wr_en;
                rsp_status_next = upd.status;
                state_next      = S_REPLY;
            end

            // Add: walk for the lowest free slot.
            S_ADD: begin
                if (!cur_used) begin
                    used_next[idx_reg] = 1'b1;
                    ram_wr_en          = 1'b1;
                    ram_wr_data.phase  = PH_WAIT;
                    ram_wr_data.count  = cmd_reg.delay;
                    rsp_status_next    = ST_OK;
                    rsp_slot_next      = 6'(idx_reg);
                    state_next         = S_REPLY;
                end else if (idx_last) begin
                    rsp_status_next = ST_FULL;
                    rsp_slot_next   = '0;
                    state_next      = S_REPLY;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Tick: read each used slot, skip free ones.
            S_TICK_SCAN: begin
                if (cur_used) begin
                    ram_rd_en  = 1'b1;
                    state_next = S_TICK_EVAL;
                end else if (idx_last) begin
                    state_next = S_FLUSH;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Tick: update the slot; a new expiry pushes the held one out.
            S_TICK_EVAL: begin
                if (!(upd.fire && pend_valid_reg && !out_free)) begin
                    ram_wr_en = upd.wr_en;
                    if (upd.fire) begin
                        if (pend_valid_reg) begin
                            m_valid_next         = 1'b1;
                            m_data_next.kind     = KIND_EXPIRY;
                            m_data_next.status   = ST_OK;
                            m_data_next.slot_out = 6'(pend_slot_reg);
                            m_data_next.last     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                        ev_cnt_next     = ev_cnt_reg + EV_W'(1);
                    end
                    if (idx_last) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_TICK_SCAN;
                    end
                end
            end

            // End of tick: the held expiry goes out as the final beat.
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.kind     = KIND_EXPIRY;
                    m_data_next.status   = ST_OK;
                    m_data_next.slot_out = 6'(pend_slot_reg);
                    m_data_next.last     = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = S_IDLE;
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.kind     = KIND_REPLY;
                    m_data_next.status   = rsp_status_reg;
                    m_data_next.slot_out = rsp_slot_reg;
                    m_data_next.last     = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, slot flags and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            ev_cnt_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            ev_cnt_reg     <= ev_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        pend_slot_reg  <= pend_slot_next;
        m_data_reg     <= m_data_next;
    end

endmodule

/* rtl/mcst_checker.sv */
// Port-level checker for the multi-slot countdown timer, bound to the top.
// Depends on mcst_pkg and multi_slot_countdown_timer_top.
module mcst_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input mcst_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input mcst_pkg::out_t m_data
);
    import mcst_pkg::*;

    // The block works on one beat at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous beat still in work");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // A command reply is always the only result of its command.
    a_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_REPLY |-> m_data.last)
        else $error("command reply without last");

    // Expiry events carry no error.
    a_expiry_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_EXPIRY |-> m_data.status == ST_OK)
        else $error("expiry event with nonzero status");

    // A table-full reply names slot zero.
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_REPLY && m_data.status == ST_FULL
            |-> m_data.slot_out == 6'd0)
        else $error("table-full reply with nonzero slot");

endmodule

bind multi_slot_countdown_timer_top mcst_checker u_mcst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* bench/multi_slot_countdown_timer_top_tb.sv */
// Self-checking testbench for the multi-slot countdown timer top level.
// Depends on mcst_pkg and multi_slot_countdown_timer_top. A scoreboard
// class predicts reply and expiry beats, and tasks drive the input channel.
module multi_slot_countdown_timer_top_tb;

    import mcst_pkg::*;

    localparam int SLOTS          = 16;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 4 * SLOTS + 40;
    localparam int PHASE_ITEMS    = 20;
    localparam int MAX_REPORTS    = 50;

    // Tracks the slot table and holds the beats the block still owes.
    class timer_scoreboard;
        bit          slot_used  [SLOTS];
        logic [1:0]  slot_phase [SLOTS];
        logic [15:0] ticks_left [SLOTS];
        out_t        owed_q [$];
        int          errors;

        function new();
            int i;
            for (i = 0; i < SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_phase[i] = PH_WAIT;
                ticks_left[i] = '0;
            end
            errors = 0;
        endfunction

        function void owe_beat(logic kind, logic [2:0] status, logic [5:0] slot,
                               logic last);
            out_t r;
            r.kind     = kind;
            r.status   = status;
            r.slot_out = slot;
            r.last     = last;
            owed_q.push_back(r);
        endfunction

        // Update the slot table for one accepted input beat.
        function void note_input(in_t cmd_in);
            int         idx;
            int         fired;
            bit         placed;
            logic [2:0] st;
            out_t       tail;
            placed = 1'b0;
            fired  = 0;
            case (cmd_in.op)
                OP_ADD: begin
                    for (idx = 0; idx < SLOTS; idx++) begin
                        if (!placed && !slot_used[idx]) begin
                            slot_used[idx]  = 1'b1;
                            slot_phase[idx] = PH_WAIT;
                            ticks_left[idx] = cmd_in.delay;
                            placed          = 1'b1;
                            owe_beat(KIND_REPLY, ST_OK, 6'(idx), 1'b1);
                        end
                    end
                    if (!placed)
                        owe_beat(KIND_REPLY, ST_FULL, 6'd0, 1'b1);
                end
                OP_CANCEL: begin
                    if (cmd_in.slot_id >= SLOTS) begin
                        st = ST_INVALID;
                    end else if (!slot_used[cmd_in.slot_id]) begin
                        st = ST_INVALID;
                    end else if (slot_phase[cmd_in.slot_id] == PH_WAIT) begin
                        slot_phase[cmd_in.slot_id] = PH_CANCEL;
                        st = ST_OK;
                    end else if (slot_phase[cmd_in.slot_id] == PH_CANCEL) begin
                        st = ST_CANCELED;
                    end else begin
                        st = ST_BUSY;
                    end
                    owe_beat(KIND_REPLY, st, cmd_in.slot_id, 1'b1);
                end
                OP_RELEASE: begin
                    if (cmd_in.slot_id >= SLOTS) begin
                        owe_beat(KIND_REPLY, ST_INVALID, cmd_in.slot_id, 1'b1);
                    end else begin
                        slot_used[cmd_in.slot_id]  = 1'b0;
                        slot_phase[cmd_in.slot_id] = PH_WAIT;
                        ticks_left[cmd_in.slot_id] = '0;
                        owe_beat(KIND_REPLY, ST_OK, cmd_in.slot_id, 1'b1);
                    end
                end
                default: begin
                    // Tick: count down waiting slots, fire those already at zero.
                    for (idx = 0; idx < SLOTS; idx++) begin
                        if (slot_used[idx] && slot_phase[idx] == PH_WAIT) begin
                            if (ticks_left[idx] != 16'd0) begin
                                ticks_left[idx] = ticks_left[idx] - 16'd1;
                            end else if (fired < MAX_EVENTS) begin
                                slot_phase[idx] = PH_DONE;
                                owe_beat(KIND_EXPIRY, ST_OK, 6'(idx), 1'b0);
                                fired++;
                            end
                        end
                    end
                    // The final expiry beat of a tick carries last.
                    if (fired > 0) begin
                        tail      = owed_q.pop_back();
                        tail.last = 1'b1;
                        owed_q.push_back(tail);
                    end
                end
            endcase
        endfunction

        // Compare one accepted result beat with the oldest owed beat.
        function void check_result(out_t got);
            out_t want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat: kind %0d status %0d slot %0d last %0d",
                             $time, got.kind, got.status, got.slot_out, got.last);
                return;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.slot_out !== want.slot_out || got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch: expected kind %0d status %0d slot %0d last %0d, %s",
                             $time, want.kind, want.status, want.slot_out, want.last,
                             $sformatf("actual kind %0d status %0d slot %0d last %0d",
                                       got.kind, got.status, got.slot_out, got.last));
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void check_drained();
            if (owed_q.size() != 0) begin
                errors += owed_q.size();
                $display("%0t: %0d expected beats never arrived", $time, owed_q.size());
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int  snd_idle_pct;
    int  rcv_stall_pct;
    bit  rx_hold_req;

    timer_scoreboard sb;

    multi_slot_countdown_timer_top #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // Monitor both channels on the clock edge at which a beat moves.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (s_valid && s_ready)
                sb.note_input(s_data);
        end
    end

    // Result side: random stalls, plus one long hold when asked.
    initial begin
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    function automatic in_t cmd(logic [1:0] op, logic [15:0] delay, logic [5:0] id);
        in_t c;
        c.op      = op;
        c.delay   = delay;
        c.slot_id = id;
        return c;
    endfunction

    // Offer one beat, after a random gap, and wait until it is taken.
    task automatic send_item(in_t item);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Mostly short delays so slots expire, with some full-range ones.
    function automatic in_t random_cmd();
        int          r;
        logic [1:0]  op;
        logic [15:0] delay;
        logic [5:0]  id;
        r = $urandom_range(99);
        if (r < 35)      op = OP_ADD;
        else if (r < 50) op = OP_CANCEL;
        else if (r < 70) op = OP_RELEASE;
        else             op = OP_TICK;
        r = $urandom_range(9);
        if (r < 6)       delay = 16'($urandom_range(3));
        else if (r < 9)  delay = 16'($urandom_range(65535));
        else             delay = 16'hFFFF;
        if ($urandom_range(9) < 8) id = 6'($urandom_range(SLOTS - 1));
        else                       id = 6'($urandom_range(63));
        return cmd(op, delay, id);
    endfunction

    task automatic run_random(int count);
        int n;
        for (n = 0; n < count; n++)
            send_item(random_cmd());
    endtask

    // Empty the table, overfill it, then expire every slot in one tick.
    task automatic fill_and_expire();
        int i;
        for (i = 0; i < SLOTS; i++)
            send_item(cmd(OP_RELEASE, 16'($urandom_range(65535)), 6'(i)));
        for (i = 0; i <= SLOTS; i++)
            send_item(cmd(OP_ADD, 16'd0, 6'($urandom_range(63))));
        send_item(cmd(OP_TICK, 16'($urandom_range(65535)), 6'($urandom_range(63))));
    endtask

    // Main sequence.
    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        rx_hold_req   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-table corners, invalid ids, every cancel outcome.
        send_item(cmd(OP_TICK,    16'h0000, 6'd0));
        send_item(cmd(OP_CANCEL,  16'h0000, 6'd3));
        send_item(cmd(OP_CANCEL,  16'hFFFF, 6'd63));
        send_item(cmd(OP_RELEASE, 16'h0000, 6'd16));
        send_item(cmd(OP_RELEASE, 16'h0000, 6'd5));
        send_item(cmd(OP_ADD,     16'h0000, 6'd0));
        send_item(cmd(OP_ADD,     16'hFFFF, 6'd63));
        send_item(cmd(OP_ADD,     16'h0001, 6'd0));
        send_item(cmd(OP_CANCEL,  16'h0000, 6'd1));
        send_item(cmd(OP_CANCEL,  16'h0000, 6'd1));
        send_item(cmd(OP_TICK,    16'hFFFF, 6'd63));
        send_item(cmd(OP_CANCEL,  16'h0000, 6'd0));
        send_item(cmd(OP_TICK,    16'h0000, 6'd0));
        send_item(cmd(OP_TICK,    16'h0000, 6'd0));
        send_item(cmd(OP_RELEASE, 16'h0000, 6'd0));
        send_item(cmd(OP_RELEASE, 16'h0000, 6'd1));
        send_item(cmd(OP_ADD,     16'h0000, 6'd63));
        send_item(cmd(OP_ADD,     16'h0000, 6'd0));
        send_item(cmd(OP_ADD,     16'h0002, 6'd0));
        send_item(cmd(OP_TICK,    16'h0000, 6'd0));
        send_item(cmd(OP_RELEASE, 16'h0000, 6'd15));
        send_item(cmd(OP_RELEASE, 16'h0000, 6'd63));

        // Random traffic, no idling on either side.
        run_random(PHASE_ITEMS);

        // Long hold on the result side while the table is filled.
        rx_hold_req = 1'b1;
        fill_and_expire();

        // Sender mostly idle.
        snd_idle_pct  = 79;
        rcv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        // Receiver mostly stalling.
        snd_idle_pct  = 0;
        rcv_stall_pct = 79;
        run_random(PHASE_ITEMS);

        // Both sides idle now and then.
        snd_idle_pct  = 24;
        rcv_stall_pct = 24;
        run_random(PHASE_ITEMS);
        fill_and_expire();

        // Drain, then allow for a quiet tick still being worked.
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mcst_pkg.sv
rtl/mcst_ram.sv
rtl/mcst_slot_unit.sv
rtl/multi_slot_countdown_timer_top.sv
rtl/mcst_checker.sv
bench/multi_slot_countdown_timer_top_tb.sv
